FILE: rtl/core/spgc_pkg.sv
// ----------------------------------------------------------------------------
// spgc_pkg
// Shared constants and helper functions for the sector pattern generator and
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spgc_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int POS_W        = $clog2(SECTOR_BYTES);
    localparam int ADDR_W       = 32;
    localparam int BCD_DIGITS   = 10;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int PASS_W       = 16;
    localparam int STEP_BITS    = 8;
    localparam int SHIFT_AMT    = 3;

    localparam logic [POS_W-1:0] POS_FIRST     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SHIFT_LO  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_PASS_HI   = POS_W'(16);
    localparam logic [POS_W-1:0] POS_PASS_LO   = POS_W'(17);
    localparam logic [POS_W-1:0] POS_SEED      = POS_W'(18);
    localparam logic [POS_W-1:0] POS_RUN_END   = POS_W'(495);
    localparam logic [POS_W-1:0] POS_TAIL_SHFT = POS_W'(496);
    localparam logic [POS_W-1:0] POS_TAIL_ADDR = POS_W'(504);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(SECTOR_BYTES - 1);

    // Eight double-dabble steps: adjust every digit, then shift in one bit.
    function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
                                                  input logic [STEP_BITS-1:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (acc[4*d +: 4] >= 4'd5)
                begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[STEP_BITS-1-s]};
        end
        return acc;
    endfunction

    // Byte k of the big-endian eight-byte view of a digit word.
    function automatic logic [7:0] digit_byte(input logic [BCD_W-1:0] digits,
                                              input logic [2:0] k);
        logic [63:0] word;
        logic [2:0]  idx;
        word = {{(64 - BCD_W){1'b0}}, digits};
        idx  = 3'd7 - k;
        return word[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/spgc_bcd_pipe.sv
// ----------------------------------------------------------------------------
// spgc_bcd_pipe
// Four-stage double-dabble converter from a 32-bit binary value to ten BCD
// digits; the result loads once the start token reaches the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spgc_bcd_pipe
    import spgc_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire  [ADDR_W-1:0]       value,
    output logic [BCD_W-1:0]        digits
);

    localparam int STAGES = ADDR_W / STEP_BITS - 1;
    localparam int REM_W  = ADDR_W - STEP_BITS;

    logic [BCD_W-1:0] bcd_reg  [STAGES];
    logic [BCD_W-1:0] bcd_next [STAGES];
    logic [REM_W-1:0] rem_reg  [STAGES];
    logic [REM_W-1:0] rem_next [STAGES];
    logic [STAGES-1:0] tok_reg;
    logic [STAGES-1:0] tok_next;
    logic [BCD_W-1:0] digits_reg;
    logic [BCD_W-1:0] digits_next;

    always_comb
    begin
        bcd_next[0] = dabble8({BCD_W{1'b0}}, value[ADDR_W-1 -: STEP_BITS]);
        rem_next[0] = value[REM_W-1:0];
        tok_next[0] = start;
        for (int i = 1; i < STAGES; i++)
        begin
            bcd_next[i] = dabble8(bcd_reg[i-1], rem_reg[i-1][REM_W-1 -: STEP_BITS]);
            rem_next[i] = {rem_reg[i-1][REM_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
            tok_next[i] = tok_reg[i-1];
        end
        digits_next = digits_reg;
        if (tok_reg[STAGES-1])
        begin
            digits_next = dabble8(bcd_reg[STAGES-1],
                                  rem_reg[STAGES-1][REM_W-1 -: STEP_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            digits_reg <= '0;
        end
        else
        begin
            tok_reg    <= tok_next;
            digits_reg <= digits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            bcd_reg[i] <= bcd_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    assign digits = digits_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sector_pattern_gen_check.sv
// ----------------------------------------------------------------------------
// sector_pattern_gen_check
// Streams the 512-byte sector test pattern one byte per item and checks
// read-back bytes against it, keeping a per-sector verdict.
// ----------------------------------------------------------------------------
// Accepted items pass through an input register and an output register.
// Throughput: one item per cycle unless m_tready is low; single compare stage.
// The address digits come from a four-stage BCD pipeline started by the
// first byte of a sector; they are ready before the fourth byte needs them.
// Reset clears the byte position, the verdict, the pass number and all
// valid flags.
`default_nettype none

module sector_pattern_gen_check
    import spgc_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [PASS_W-1:0]   cfg_data,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [39:0]         s_tdata,   // block_address[31:0], data_byte[39:32]
    input  wire  [0:0]          s_tuser,   // action[0]
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [15:0]         m_tdata,   // expected_byte[7:0], byte_mismatch[8],
                                           // sector_ok[9], zero[15:10]
    output logic                m_tlast
);

    localparam int LO_ADDR_W = STEP_BITS + SHIFT_AMT;

    logic [PASS_W-1:0]    pass_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 in_valid_reg;
    logic                 in_action_reg;
    logic [7:0]           in_data_reg;
    logic [LO_ADDR_W-1:0] in_addr_reg;
    logic [POS_W-1:0]     in_pos_reg;
    logic [7:0]           running_reg;
    logic [7:0]           running_next;
    logic                 mseen_reg;
    logic                 mseen_next;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_mis_reg;
    logic                 out_last_reg;
    logic                 out_ok_reg;

    logic                 s_accept;
    logic                 advance;
    logic                 start;
    logic [BCD_W-1:0]     addr_digits;
    logic [BCD_W-1:0]     shft_digits;
    logic [7:0]           base_run;
    logic                 base_seen;
    logic [7:0]           exp_byte;
    logic                 mis;
    logic                 last;
    logic                 ok;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign start     = s_accept && (pos_reg == POS_FIRST);

    spgc_bcd_pipe u_addr_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (s_tdata[ADDR_W-1:0]),
        .digits (addr_digits)
    );

    spgc_bcd_pipe u_shft_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  ({{SHIFT_AMT{1'b0}}, s_tdata[ADDR_W-1:SHIFT_AMT]}),
        .digits (shft_digits)
    );

    always_comb
    begin
        if (in_pos_reg == POS_FIRST)
        begin
            base_run  = in_addr_reg[7:0] + in_addr_reg[LO_ADDR_W-1:SHIFT_AMT];
            base_seen = 1'b0;
        end
        else
        begin
            base_run  = running_reg;
            base_seen = mseen_reg;
        end

        running_next = base_run;
        if (in_pos_reg < POS_SHIFT_LO)
        begin
            exp_byte = digit_byte(addr_digits, in_pos_reg[2:0]);
        end
        else if (in_pos_reg < POS_PASS_HI)
        begin
            exp_byte = digit_byte(shft_digits, in_pos_reg[2:0]);
        end
        else if (in_pos_reg == POS_PASS_HI)
        begin
            exp_byte = pass_reg[15:8];
        end
        else if (in_pos_reg == POS_PASS_LO)
        begin
            exp_byte = pass_reg[7:0];
        end
        else if (in_pos_reg == POS_SEED)
        begin
            exp_byte     = base_run + pass_reg[7:0];
            running_next = exp_byte;
        end
        else if (in_pos_reg <= POS_RUN_END)
        begin
            exp_byte     = base_run + 8'd1;
            running_next = exp_byte;
        end
        else if (in_pos_reg < POS_TAIL_ADDR)
        begin
            exp_byte = digit_byte(shft_digits, in_pos_reg[2:0]);
        end
        else
        begin
            exp_byte = digit_byte(addr_digits, in_pos_reg[2:0]);
        end

        mis        = in_action_reg && (in_data_reg != exp_byte);
        last       = (in_pos_reg == POS_LAST);
        ok         = last && !(base_seen || mis);
        mseen_next = base_seen || mis;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg      <= '0;
            pos_reg       <= '0;
            in_valid_reg  <= 1'b0;
            running_reg   <= '0;
            mseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pass_reg <= cfg_data;
            end
            if (s_accept)
            begin
                pos_reg      <= pos_reg + POS_W'(1);
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                running_reg   <= running_next;
                mseen_reg     <= mseen_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg <= s_tuser[0];
            in_data_reg   <= s_tdata[39:32];
            in_addr_reg   <= s_tdata[LO_ADDR_W-1:0];
            in_pos_reg    <= pos_reg;
        end
        if (advance)
        begin
            out_byte_reg <= exp_byte;
            out_mis_reg  <= mis;
            out_last_reg <= last;
            out_ok_reg   <= ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_ok_reg, out_mis_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
